// ===== rtl/tvsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tvsd_pkg
// Shared widths, result kind codes and tag byte values of the tagged varint
// stream decoder.
// ----------------------------------------------------------------------------
package tvsd_pkg;

	localparam int BYTE_W        = 8;
	localparam int KIND_W        = 3;
	localparam int OUT_W         = 64;
	localparam int COUNT_W       = 4;
	localparam int CHARS_W       = 32;
	localparam int VALUE_WIDTH_D = 64;

	// Result kinds.
	localparam logic [KIND_W-1:0] K_BOOL  = 3'd0;
	localparam logic [KIND_W-1:0] K_SHORT = 3'd1;
	localparam logic [KIND_W-1:0] K_INT   = 3'd2;
	localparam logic [KIND_W-1:0] K_LONG  = 3'd3;
	localparam logic [KIND_W-1:0] K_CHAR  = 3'd4;
	localparam logic [KIND_W-1:0] K_SLEN  = 3'd5;
	localparam logic [KIND_W-1:0] K_SCHR  = 3'd6;

	// Tag bytes (ASCII).
	localparam logic [BYTE_W-1:0] TAG_TRUE  = 8'h74; // 't'
	localparam logic [BYTE_W-1:0] TAG_FALSE = 8'h66; // 'f'
	localparam logic [BYTE_W-1:0] TAG_CHAR  = 8'h63; // 'c'
	localparam logic [BYTE_W-1:0] TAG_SHORT = 8'h73; // 's'
	localparam logic [BYTE_W-1:0] TAG_INT   = 8'h69; // 'i'
	localparam logic [BYTE_W-1:0] TAG_LONG  = 8'h6C; // 'l'
	localparam logic [BYTE_W-1:0] TAG_STR   = 8'h53; // 'S'

endpackage

// ===== rtl/tagged_varint_stream_decoder_top.sv =====
// Output: a result is registered at the edge accepting its completing byte.
// Throughput: one byte per cycle while pending results are taken; the parser
// state and the result register are both updated in the accepting cycle, so
// bytes may follow back to back.
// Reset: arst_n clears the parser to expect a tag and empties the output.
// ----------------------------------------------------------------------------
// tagged_varint_stream_decoder_top
// Parses a tagged byte stream (booleans, chars, signed varints and strings)
// and emits one decoded item per completing byte; unknown tags are flagged.
// ----------------------------------------------------------------------------
module tagged_varint_stream_decoder_top #(
	parameter int VALUE_WIDTH = tvsd_pkg::VALUE_WIDTH_D
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic        [tvsd_pkg::BYTE_W-1:0]    in_byte,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic        [tvsd_pkg::KIND_W-1:0]    item_kind,
	output logic signed [tvsd_pkg::OUT_W-1:0]     value,
	output logic                                  bad_tag
);
	import tvsd_pkg::*;

	// Width that int and string length values are wrapped to.
	localparam int IW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_CHAR,
		PH_HEAD,
		PH_BODY,
		PH_STR
	} phase_t;

	phase_t                   phase_q, phase_n;
	logic [KIND_W-1:0]        kind_q, kind_n;
	logic [COUNT_W-1:0]       left_q, left_n;
	logic [VALUE_WIDTH-1:0]   acc_q, acc_n;
	logic [CHARS_W-1:0]       chars_q, chars_n;

	logic                     emit;
	logic [KIND_W-1:0]        emit_kind;
	logic [OUT_W-1:0]         emit_value;
	logic                     emit_bad;
	logic                     accept;

	logic                     out_valid_q;
	logic [KIND_W-1:0]        item_kind_q;
	logic [OUT_W-1:0]         value_q;
	logic                     bad_tag_q;

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	always_comb begin
		phase_n    = phase_q;
		kind_n     = kind_q;
		left_n     = left_q;
		acc_n      = acc_q;
		chars_n    = chars_q;
		emit       = 1'b0;
		emit_kind  = K_BOOL;
		emit_value = {{(OUT_W-BYTE_W){1'b0}}, in_byte};
		emit_bad   = 1'b0;
		case (phase_q)
			PH_CHAR: begin
				phase_n   = PH_TAG;
				emit      = 1'b1;
				emit_kind = K_CHAR;
			end
			PH_HEAD: begin
				acc_n  = VALUE_WIDTH'($signed(in_byte[3:0]));
				left_n = in_byte[7:4];
				if (left_n != '0) begin
					phase_n = PH_BODY;
				end
			end
			PH_BODY: begin
				acc_n  = {acc_q[VALUE_WIDTH-BYTE_W-1:0], in_byte};
				left_n = left_q - COUNT_W'(1);
			end
			PH_STR: begin
				chars_n   = chars_q - CHARS_W'(1);
				emit      = 1'b1;
				emit_kind = K_SCHR;
				if (chars_n == '0) begin
					phase_n = PH_TAG;
				end
			end
			default: begin
				phase_n = PH_TAG;
				case (in_byte)
					TAG_TRUE: begin
						emit       = 1'b1;
						emit_value = OUT_W'(1);
					end
					TAG_FALSE: begin
						emit       = 1'b1;
						emit_value = '0;
					end
					TAG_CHAR: begin
						phase_n = PH_CHAR;
						kind_n  = K_CHAR;
					end
					TAG_SHORT: begin
						phase_n = PH_HEAD;
						kind_n  = K_SHORT;
					end
					TAG_INT: begin
						phase_n = PH_HEAD;
						kind_n  = K_INT;
					end
					TAG_LONG: begin
						phase_n = PH_HEAD;
						kind_n  = K_LONG;
					end
					TAG_STR: begin
						phase_n = PH_HEAD;
						kind_n  = K_SLEN;
					end
					default: begin
						emit     = 1'b1;
						emit_bad = 1'b1;
					end
				endcase
			end
		endcase

		// The varint ends on its head byte when the count is zero, or on the
		// last body byte; the value is then wrapped to the width of its type.
		if ((phase_q == PH_HEAD || phase_q == PH_BODY) && left_n == '0) begin
			phase_n   = PH_TAG;
			emit      = 1'b1;
			emit_kind = kind_q;
			case (kind_q)
				K_SHORT: emit_value = OUT_W'($signed(acc_n[15:0]));
				K_INT:   emit_value = OUT_W'($signed(acc_n[IW-1:0]));
				K_LONG:  emit_value = OUT_W'($signed(acc_n));
				default: begin
					emit_kind  = K_SLEN;
					emit_value = OUT_W'($signed(acc_n[IW-1:0]));
					if (!emit_value[OUT_W-1] && emit_value != '0) begin
						chars_n = emit_value[CHARS_W-1:0];
						phase_n = PH_STR;
					end else begin
						chars_n = '0;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TAG;
			kind_q      <= K_BOOL;
			left_q      <= '0;
			acc_q       <= '0;
			chars_q     <= '0;
			out_valid_q <= 1'b0;
			item_kind_q <= K_BOOL;
			value_q     <= '0;
			bad_tag_q   <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_n;
				kind_q      <= kind_n;
				left_q      <= left_n;
				acc_q       <= acc_n;
				chars_q     <= chars_n;
				out_valid_q <= emit;
				if (emit) begin
					item_kind_q <= emit_kind;
					value_q     <= emit_value;
					bad_tag_q   <= emit_bad;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign item_kind = item_kind_q;
	assign value     = value_q;
	assign bad_tag   = bad_tag_q;

	a_body_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> left_q != '0)
		else $error("body phase with no bytes left");

	a_str_has_chars: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_STR |-> chars_q != '0 && !chars_q[CHARS_W-1])
		else $error("string phase with empty or negative char count");

	a_bad_is_bool: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_tag |-> item_kind == K_BOOL && value[OUT_W-1:BYTE_W] == '0)
		else $error("bad tag result malformed");

	a_bool_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == K_BOOL && !bad_tag |-> value[OUT_W-1:1] == '0)
		else $error("boolean result out of range");

	a_no_result_on_head: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_HEAD && in_byte[7:4] != 4'd0 |=> phase_q == PH_BODY)
		else $error("varint head with count did not enter body phase");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tagged varint stream decoder testbench
// Feeds directed tag records, then random well-formed records with some
// unknown tags mixed in, under random request gaps and output stalls. A
// scoreboard class tracks the parser state and checks every result in order.
// ----------------------------------------------------------------------------
module testbench;
	import tvsd_pkg::*;

	localparam int VW    = VALUE_WIDTH_D;
	localparam int INT_W = (VW < 32) ? VW : 32;

	typedef enum logic [2:0] {AT_TAG, AT_CHAR, AT_HEAD, AT_BODY, AT_STRING} parse_phase_t;

	typedef struct {
		logic [KIND_W-1:0] kind;
		logic [OUT_W-1:0]  value;
		logic              bad;
	} decoded_t;

	class decode_scoreboard;
		parse_phase_t      phase;
		logic [KIND_W-1:0] kind;
		logic [3:0]        bytes_left;
		logic [63:0]       acc;
		logic [31:0]       chars_left;
		decoded_t          expected_q[$];
		int unsigned       errors;

		function new();
			phase      = AT_TAG;
			kind       = K_BOOL;
			bytes_left = '0;
			acc        = '0;
			chars_left = '0;
			errors     = 0;
		endfunction

		function void push_result(logic [KIND_W-1:0] k, logic [63:0] v, logic bad);
			decoded_t d;
			d.kind  = k;
			d.value = v;
			d.bad   = bad;
			expected_q = {expected_q, d};
		endfunction

		function logic [63:0] wrap_signed(logic [63:0] v, int unsigned w);
			logic [63:0] m;
			if (w >= 64)
				return v;
			m = 64'd1 << (w - 1);
			v = v & ((64'd1 << w) - 64'd1);
			return (v ^ m) - m;
		endfunction

		function void close_varint();
			logic [63:0] v;
			phase = AT_TAG;
			case (kind)
				K_SHORT: push_result(K_SHORT, wrap_signed(acc, 16), 1'b0);
				K_INT:   push_result(K_INT, wrap_signed(acc, INT_W), 1'b0);
				K_LONG:  push_result(K_LONG, wrap_signed(acc, VW), 1'b0);
				default: begin
					v = wrap_signed(acc, INT_W);
					// Only a positive length opens a run of string chars.
					if (!v[63] && v != 0) begin
						chars_left = v[31:0];
						phase = AT_STRING;
					end else begin
						chars_left = '0;
					end
					push_result(K_SLEN, v, 1'b0);
				end
			endcase
		endfunction

		function void note_byte(logic [7:0] b);
			case (phase)
				AT_CHAR: begin
					phase = AT_TAG;
					push_result(K_CHAR, {56'd0, b}, 1'b0);
				end
				AT_HEAD: begin
					acc = b[3] ? {60'hFFF_FFFF_FFFF_FFFF, b[3:0]} : {60'd0, b[3:0]};
					bytes_left = b[7:4];
					if (bytes_left == 0)
						close_varint();
					else
						phase = AT_BODY;
				end
				AT_BODY: begin
					acc = {acc[55:0], b};
					bytes_left = bytes_left - 4'd1;
					if (bytes_left == 0)
						close_varint();
				end
				AT_STRING: begin
					chars_left = chars_left - 32'd1;
					if (chars_left == 0)
						phase = AT_TAG;
					push_result(K_SCHR, {56'd0, b}, 1'b0);
				end
				default: begin
					phase = AT_TAG;
					case (b)
						TAG_TRUE:  push_result(K_BOOL, 64'd1, 1'b0);
						TAG_FALSE: push_result(K_BOOL, 64'd0, 1'b0);
						TAG_CHAR: begin
							kind = K_CHAR;
							phase = AT_CHAR;
						end
						TAG_SHORT: begin
							kind = K_SHORT;
							phase = AT_HEAD;
						end
						TAG_INT: begin
							kind = K_INT;
							phase = AT_HEAD;
						end
						TAG_LONG: begin
							kind = K_LONG;
							phase = AT_HEAD;
						end
						TAG_STR: begin
							kind = K_SLEN;
							phase = AT_HEAD;
						end
						default: push_result(K_BOOL, {56'd0, b}, 1'b1);
					endcase
				end
			endcase
		endfunction

		function void check_result(logic [KIND_W-1:0] k, logic [63:0] v, logic bad);
			decoded_t e;
			if (expected_q.size() == 0) begin
				$display("%0t ns: unexpected result: item_kind %0d value %0d bad_tag %0b",
					$time, k, $signed(v), bad);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (k !== e.kind) begin
				$display("%0t ns: item_kind mismatch: expected %0d, actual %0d",
					$time, e.kind, k);
				errors++;
			end
			if (v !== e.value) begin
				$display("%0t ns: value mismatch: expected %0d, actual %0d",
					$time, $signed(e.value), $signed(v));
				errors++;
			end
			if (bad !== e.bad) begin
				$display("%0t ns: bad_tag mismatch: expected %0b, actual %0b",
					$time, e.bad, bad);
				errors++;
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	logic [BYTE_W-1:0]       in_byte   = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [KIND_W-1:0]       item_kind;
	logic signed [OUT_W-1:0] value;
	logic                    bad_tag;

	decode_scoreboard sb = new();
	logic [7:0]       stream_q[$];
	int unsigned      calm_tx = 0;
	int unsigned      calm_rx = 0;
	int unsigned      stall_left = 0;

	tagged_varint_stream_decoder_top #(
		.VALUE_WIDTH(VW)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_kind(item_kind),
		.value    (value),
		.bad_tag  (bad_tag)
	);

	always #2 clk = ~clk;

	// Mostly short gaps, a few long ones, and now and then a calm stretch.
	function automatic int unsigned pick_gap(ref int unsigned calm);
		int unsigned r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(item_kind, value, bad_tag);
			if (in_valid && in_ready)
				sb.note_byte(in_byte);
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = ($urandom_range(0, 2) == 0) ? pick_gap(calm_rx) : 0;
			end
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_byte(logic [7:0] b);
		int unsigned gap;
		gap = pick_gap(calm_tx);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_stream();
		while (stream_q.size() > 0)
			send_byte(stream_q.pop_front());
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic put_byte(logic [7:0] b);
		stream_q = {stream_q, b};
	endtask

	task automatic add_body_bytes(int unsigned n);
		repeat (n) begin
			case ($urandom_range(0, 5))
				0:       put_byte(8'h00);
				1:       put_byte(8'hFF);
				default: put_byte(8'($urandom));
			endcase
		end
	endtask

	task automatic add_number(logic [7:0] tag);
		int unsigned cnt;
		cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
		put_byte(tag);
		put_byte({4'(cnt), 4'($urandom)});
		add_body_bytes(cnt);
	endtask

	// Builds the length so that the char run stays short.
	task automatic add_string();
		int unsigned len;
		int unsigned cnt;
		len = 0;
		put_byte(TAG_STR);
		case ($urandom_range(0, 5))
			0, 1: begin
				len = $urandom_range(1, 7);
				put_byte({4'd0, 4'(len)});
			end
			2: begin
				len = $urandom_range(0, 40);
				put_byte(8'h10);
				put_byte(8'(len));
			end
			3: begin
				// Upper bits fall away when wrapped to the length width.
				cnt = $urandom_range(4, 15);
				len = $urandom_range(0, 9);
				put_byte({4'(cnt), 4'($urandom)});
				add_body_bytes(cnt - 4);
				put_byte(8'h00);
				put_byte(8'h00);
				put_byte(8'h00);
				put_byte(8'(len));
			end
			4: begin
				cnt = $urandom_range(0, 3);
				put_byte({4'(cnt), 1'b1, 3'($urandom)});
				add_body_bytes(cnt);
			end
			default: begin
				if ($urandom_range(0, 1) == 0) begin
					put_byte(8'h00);
				end else begin
					cnt = $urandom_range(4, 15);
					put_byte({4'(cnt), 4'($urandom)});
					add_body_bytes(cnt - 4);
					put_byte({1'b1, 7'($urandom)});
					add_body_bytes(3);
				end
			end
		endcase
		repeat (len)
			put_byte(8'($urandom));
	endtask

	task automatic add_random_records(int unsigned target);
		int unsigned r;
		logic [7:0]  b;
		while (stream_q.size() < target) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				put_byte($urandom_range(0, 1) ? TAG_TRUE : TAG_FALSE);
			end else if (r < 18) begin
				put_byte(TAG_CHAR);
				put_byte(8'($urandom));
			end else if (r < 55) begin
				case ($urandom_range(0, 2))
					0:       add_number(TAG_SHORT);
					1:       add_number(TAG_INT);
					default: add_number(TAG_LONG);
				endcase
			end else if (r < 82) begin
				add_string();
			end else begin
				do b = 8'($urandom);
				while (b inside {TAG_CHAR, TAG_SHORT, TAG_INT, TAG_LONG, TAG_STR});
				put_byte(b);
			end
		end
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		stream_q = {TAG_TRUE, TAG_FALSE,
			TAG_CHAR, 8'h00, TAG_CHAR, 8'hFF,
			TAG_SHORT, 8'h07, TAG_SHORT, 8'h08,
			TAG_SHORT, 8'h20, 8'h7F, 8'hFF,
			TAG_SHORT, 8'h2F, 8'h80, 8'h00,
			TAG_INT, 8'h40, 8'h7F, 8'hFF, 8'hFF, 8'hFF,
			TAG_INT, 8'h4F, 8'h80, 8'h00, 8'h00, 8'h00,
			TAG_LONG, 8'h80, 8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			TAG_LONG, 8'h88, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			TAG_LONG, 8'hF5};
		// A count above eight: fifteen further bytes, only the low 64 bits kept.
		repeat (15)
			put_byte(8'($urandom));
		stream_q = {stream_q, TAG_STR, 8'h03, 8'h61, 8'h62, 8'h63,
			TAG_STR, 8'h00, TAG_STR, 8'h0F, 8'h00, 8'hFF, TAG_TRUE};
		send_stream();
		wait_drained();

		// Each chunk ends on a record boundary and is fully drained.
		repeat (4) begin
			add_random_records(250);
			send_stream();
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#2ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/tvsd_pkg.sv
rtl/tagged_varint_stream_decoder_top.sv
tb/testbench.sv
